[hw/rtl/fsr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fsr_pkg;

  // Default internal word width and the fixed widths of the result fields.
  localparam int WORD_BITS_DEF = 32;
  localparam int NUM_BITS      = 32;
  localparam int DEN_BITS      = 31;

  // Character codes that carry meaning in an expression.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Parse phase of the current term.
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_NUM   = 2'd1;
  localparam logic [1:0] PH_DEN   = 2'd2;

endpackage

`default_nettype wire

[hw/rtl/fraction_sum_reducer_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                  Word contents
// char     in         char_valid / char_ready    ch (8 bits), last (1 bit)
// res      out        res_valid / res_ready      numerator (32, signed),
//                                                denominator (31), overflow
//
// A character that does not close a term is taken while the block is idle, so plain
// digits stream at one word per cycle. A character that closes a term starts the
// term arithmetic, all of it on one shared (WORD_BITS+1)-bit adder: up to three
// bit-serial multiplies, one add (repeated once after a swap), a binary gcd with
// shared factors of two stripped first, and two restoring divisions. New
// characters wait until the arithmetic is done. The last character also posts
// the result word through the emit state.
// Reset (rst, synchronous, active high) clears the running sum to 0/1, the term
// parser and the sticky overflow flag, and empties the result register.
// A stalled result register holds the block in its emit state; new characters
// are taken again once the word has moved into the result register.
module fraction_sum_reducer_core #(
  parameter int WORD_BITS = fsr_pkg::WORD_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 char_valid,
  output logic                                char_ready,
  input  wire  [7:0]                          ch,
  input  wire                                 last,
  output logic                                res_valid,
  input  wire                                 res_ready,
  output logic signed [fsr_pkg::NUM_BITS-1:0] numerator,
  output logic [fsr_pkg::DEN_BITS-1:0]        denominator,
  output logic                                overflow
);

  // Magnitudes are kept in WM bits, so every stored value is at most LIM.
  localparam int WM = WORD_BITS - 1;
  localparam int AW = WORD_BITS + 1;
  localparam int DW = WORD_BITS + 3;
  localparam int XW = WORD_BITS + fsr_pkg::NUM_BITS + 1;
  localparam int CW = $clog2(WM);
  localparam logic [WM-1:0] LIM = {WM{1'b1}};
  localparam logic [CW-1:0] CNT_TOP = CW'(WM - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LOAD   = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_ADD    = 4'd3;
  localparam logic [3:0] S_GSHIFT = 4'd4;
  localparam logic [3:0] S_GCD    = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_EMIT   = 4'd7;

  // Which cross product the multiplier is working on.
  localparam logic [1:0] MJ_P = 2'd0;  // sum numerator times term denominator
  localparam logic [1:0] MJ_Q = 2'd1;  // term numerator times sum denominator
  localparam logic [1:0] MJ_D = 2'd2;  // product of the two denominators

  localparam logic DJ_NUM = 1'b0;
  localparam logic DJ_DEN = 1'b1;

  logic [3:0]    state;

  // Term parser.
  logic [WM-1:0] term_num;
  logic [WM-1:0] term_den;
  logic          term_negative;
  logic [1:0]    parse_phase;
  logic          prev_was_sign;
  logic          have_sum;
  logic          overflow_seen;
  logic          pend_last;

  // Captured term and running sum, in sign and magnitude form.
  logic [WM-1:0] tn_mag;
  logic          tn_neg;
  logic [WM-1:0] td;
  logic [WM-1:0] sum_mag;
  logic          sum_neg;
  logic [WM-1:0] sum_den;

  // Work registers of the term arithmetic.
  logic [WM-1:0] p_mag;
  logic          p_neg;
  logic [WM-1:0] q_mag;
  logic          q_neg;
  logic [WM-1:0] nd;
  logic [WM-1:0] acc;
  logic [CW-1:0] cnt;
  logic [1:0]    mul_sel;
  logic          div_sel;
  logic [WM-1:0] ga;
  logic [WM-1:0] gb;
  logic [WM-1:0] rem;
  logic [WM-1:0] dq;

  //--------------------------------------------------------------------------
  // Character decode and digit append.
  //--------------------------------------------------------------------------
  logic          is_plus;
  logic          is_minus;
  logic          is_sign;
  logic          is_digit;
  logic          is_slash;
  logic [7:0]    ch_off;
  logic [3:0]    dig;
  logic [WM-1:0] app_src;
  logic [DW-1:0] app_wide;
  logic          app_sat;
  logic [WM-1:0] app_val;

  assign is_plus  = (ch == fsr_pkg::CH_PLUS);
  assign is_minus = (ch == fsr_pkg::CH_MINUS);
  assign is_sign  = is_plus || is_minus;
  assign is_digit = (ch >= fsr_pkg::CH_ZERO) && (ch <= fsr_pkg::CH_NINE);
  assign is_slash = (ch == fsr_pkg::CH_SLASH);
  assign ch_off   = ch - fsr_pkg::CH_ZERO;
  assign dig      = ch_off[3:0];

  // Times ten is two shifted copies; a value past LIM saturates.
  assign app_src  = (parse_phase == fsr_pkg::PH_DEN) ? term_den : term_num;
  assign app_wide = (DW'(app_src) << 3) + (DW'(app_src) << 1) + DW'(dig);
  assign app_sat  = app_wide > DW'(LIM);
  assign app_val  = app_sat ? LIM : app_wide[WM-1:0];

  logic [WM-1:0] nt_num;
  logic [WM-1:0] nt_den;
  logic          nt_neg;
  logic [1:0]    nt_phase;
  logic          nt_prev;
  logic          fin_old;
  logic          fin_last;
  logic          fin;

  always_comb begin
    nt_num   = term_num;
    nt_den   = term_den;
    nt_neg   = term_negative;
    nt_phase = parse_phase;
    nt_prev  = prev_was_sign;
    if (is_sign) begin
      if (prev_was_sign) begin
        // Leading or doubled signs fold into the sign of the coming term.
        if (is_minus) begin
          nt_neg = !term_negative;
        end
      end else begin
        if (parse_phase != fsr_pkg::PH_START) begin
          nt_num   = '0;
          nt_den   = '0;
          nt_phase = fsr_pkg::PH_START;
        end
        nt_neg = is_minus;
      end
      nt_prev = 1'b1;
    end else if (is_digit) begin
      if (parse_phase == fsr_pkg::PH_DEN) begin
        nt_den = app_val;
      end else begin
        nt_num   = app_val;
        nt_phase = fsr_pkg::PH_NUM;
      end
      nt_prev = 1'b0;
    end else if (is_slash) begin
      nt_phase = fsr_pkg::PH_DEN;
      nt_prev  = 1'b0;
    end
  end

  // A separating sign closes the term before it; the last character closes
  // whatever term it leaves open.
  assign fin_old  = is_sign && !prev_was_sign && (parse_phase != fsr_pkg::PH_START);
  assign fin_last = last && (nt_phase != fsr_pkg::PH_START);
  assign fin      = fin_old || fin_last;

  //--------------------------------------------------------------------------
  // Shared adder. Subtraction adds the complement; the carry out is set when
  // the first operand is not below the second.
  //--------------------------------------------------------------------------
  logic [AW-1:0] alu_x;
  logic [AW-1:0] alu_y;
  logic          alu_sub;
  logic [AW:0]   alu_full;
  logic [AW-1:0] alu_res;
  logic          alu_carry;
  logic          alu_big;

  logic [WM-1:0] mul_a;
  logic [WM-1:0] mul_b;
  logic          mul_bit;
  logic [WM:0]   div_pr;

  always_comb begin
    case (mul_sel)
      MJ_P: begin
        mul_a = sum_mag;
        mul_b = td;
      end
      MJ_Q: begin
        mul_a = tn_mag;
        mul_b = sum_den;
      end
      default: begin
        mul_a = sum_den;
        mul_b = td;
      end
    endcase
  end

  assign mul_bit = mul_b[cnt];
  assign div_pr  = {rem, dq[WM-1]};

  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b0;
    case (state)
      S_MUL: begin
        alu_x = {1'b0, acc, 1'b0};
        alu_y = mul_bit ? AW'(mul_a) : '0;
      end
      S_ADD: begin
        alu_x   = AW'(p_mag);
        alu_y   = AW'(q_mag);
        alu_sub = (p_neg != q_neg);
      end
      S_GCD: begin
        alu_x   = AW'(ga);
        alu_y   = AW'(gb);
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_x   = AW'(div_pr);
        alu_y   = AW'(gb);
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_full  = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)}
                   + (AW + 1)'(alu_sub);
  assign alu_res   = alu_full[AW-1:0];
  assign alu_carry = alu_full[AW];
  // A sum or partial product above LIM has left the word range.
  assign alu_big   = (alu_res[AW-1:WM] != '0);

  logic [WM-1:0] div_rem_next;
  logic [WM-1:0] div_q_next;

  assign div_rem_next = alu_carry ? alu_res[WM-1:0] : div_pr[WM-1:0];
  assign div_q_next   = {dq[WM-2:0], alu_carry};

  //--------------------------------------------------------------------------
  // Result formatting.
  //--------------------------------------------------------------------------
  logic [WM-1:0] d_eff;
  logic [3:0]    done_state;
  logic [XW-1:0] mag_x;
  logic [XW-1:0] sval;
  logic [XW-1:0] den_x;
  logic          num_fits;
  logic          den_fits;

  assign d_eff      = (td == '0) ? WM'(1) : td;
  assign done_state = pend_last ? S_EMIT : S_IDLE;
  assign mag_x      = XW'(sum_mag);
  assign sval       = sum_neg ? (~mag_x + XW'(1)) : mag_x;
  assign den_x      = XW'(sum_den);
  assign num_fits   = (sval[XW-1:fsr_pkg::NUM_BITS-1]
                       == {(XW - fsr_pkg::NUM_BITS + 1){sval[fsr_pkg::NUM_BITS-1]}});
  assign den_fits   = (den_x[XW-1:fsr_pkg::DEN_BITS] == '0);

  assign char_ready = (state == S_IDLE);

  //--------------------------------------------------------------------------
  // Sequencer.
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      term_num      <= '0;
      term_den      <= '0;
      term_negative <= 1'b0;
      parse_phase   <= fsr_pkg::PH_START;
      prev_was_sign <= 1'b1;
      have_sum      <= 1'b0;
      overflow_seen <= 1'b0;
      pend_last     <= 1'b0;
      sum_mag       <= '0;
      sum_neg       <= 1'b0;
      sum_den       <= WM'(1);
      res_valid     <= 1'b0;
    end else begin
      // The emit state reloads the result register itself.
      if (res_valid && res_ready && (state != S_EMIT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (char_valid) begin
            if (is_digit && app_sat) begin
              overflow_seen <= 1'b1;
            end
            if (fin) begin
              tn_mag <= fin_old ? term_num : nt_num;
              tn_neg <= fin_old ? term_negative : nt_neg;
              td     <= fin_old ? term_den : nt_den;
            end
            if (last) begin
              term_num      <= '0;
              term_den      <= '0;
              term_negative <= 1'b0;
              parse_phase   <= fsr_pkg::PH_START;
              prev_was_sign <= 1'b1;
            end else begin
              term_num      <= nt_num;
              term_den      <= nt_den;
              term_negative <= nt_neg;
              parse_phase   <= nt_phase;
              prev_was_sign <= nt_prev;
            end
            pend_last <= last;
            if (fin) begin
              state <= S_LOAD;
            end else if (last) begin
              state <= S_EMIT;
            end
          end
        end
        S_LOAD: begin
          // A missing or zero denominator counts as one and flags overflow.
          if (td == '0) begin
            overflow_seen <= 1'b1;
          end
          td       <= d_eff;
          have_sum <= 1'b1;
          if (!have_sum) begin
            sum_mag <= tn_mag;
            sum_neg <= tn_neg;
            sum_den <= d_eff;
            state   <= done_state;
          end else if (sum_den == d_eff) begin
            p_mag <= sum_mag;
            p_neg <= sum_neg;
            q_mag <= tn_mag;
            q_neg <= tn_neg;
            nd    <= d_eff;
            state <= S_ADD;
          end else begin
            acc     <= '0;
            cnt     <= CNT_TOP;
            mul_sel <= MJ_P;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          // Multiplier bits are taken from the top, so the partial product
          // only grows and can be checked against LIM at every step.
          if (alu_big) begin
            overflow_seen <= 1'b1;
            state         <= done_state;
          end else if (cnt != '0) begin
            acc <= alu_res[WM-1:0];
            cnt <= cnt - CW'(1);
          end else begin
            acc <= '0;
            cnt <= CNT_TOP;
            case (mul_sel)
              MJ_P: begin
                p_mag   <= alu_res[WM-1:0];
                p_neg   <= sum_neg;
                mul_sel <= MJ_Q;
              end
              MJ_Q: begin
                q_mag   <= alu_res[WM-1:0];
                q_neg   <= tn_neg;
                mul_sel <= MJ_D;
              end
              default: begin
                nd    <= alu_res[WM-1:0];
                state <= S_ADD;
              end
            endcase
          end
        end
        S_ADD: begin
          if (!alu_sub) begin
            if (alu_big) begin
              overflow_seen <= 1'b1;
              state         <= done_state;
            end else begin
              p_mag <= alu_res[WM-1:0];
              ga    <= alu_res[WM-1:0];
              gb    <= nd;
              state <= S_GSHIFT;
            end
          end else if (alu_carry) begin
            p_mag <= alu_res[WM-1:0];
            ga    <= alu_res[WM-1:0];
            gb    <= nd;
            state <= S_GSHIFT;
          end else begin
            // The smaller magnitude came first; swap and subtract again.
            p_mag <= q_mag;
            p_neg <= q_neg;
            q_mag <= p_mag;
            q_neg <= p_neg;
          end
        end
        S_GSHIFT: begin
          // Shared factors of two are stripped from both values; what is left
          // of them are the dividends for the final divisions.
          if (ga == '0) begin
            sum_mag <= '0;
            sum_neg <= 1'b0;
            sum_den <= WM'(1);
            state   <= done_state;
          end else if (!ga[0] && !gb[0]) begin
            ga <= ga >> 1;
            gb <= gb >> 1;
          end else begin
            p_mag <= ga;
            nd    <= gb;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (ga == '0) begin
            dq      <= p_mag;
            rem     <= '0;
            cnt     <= CNT_TOP;
            div_sel <= DJ_NUM;
            state   <= S_DIV;
          end else if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (alu_carry) begin
            ga <= alu_res[WM-1:0];
          end else begin
            ga <= gb;
            gb <= ga;
          end
        end
        S_DIV: begin
          if (cnt != '0) begin
            rem <= div_rem_next;
            dq  <= div_q_next;
            cnt <= cnt - CW'(1);
          end else if (div_sel == DJ_NUM) begin
            sum_mag <= div_q_next;
            sum_neg <= p_neg;
            dq      <= nd;
            rem     <= '0;
            cnt     <= CNT_TOP;
            div_sel <= DJ_DEN;
          end else begin
            sum_den <= div_q_next;
            state   <= done_state;
          end
        end
        S_EMIT: begin
          if (!res_valid || res_ready) begin
            res_valid     <= 1'b1;
            numerator     <= sval[fsr_pkg::NUM_BITS-1:0];
            denominator   <= den_x[fsr_pkg::DEN_BITS-1:0];
            overflow      <= overflow_seen || !num_fits || !den_fits;
            sum_mag       <= '0;
            sum_neg       <= 1'b0;
            sum_den       <= WM'(1);
            have_sum      <= 1'b0;
            overflow_seen <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Assertions.
  //--------------------------------------------------------------------------
  a_sum_den_nonzero : assert property (@(posedge clk) disable iff (rst)
    sum_den != '0)
    else $error("running denominator became zero");

  a_gcd_divisor_nonzero : assert property (@(posedge clk) disable iff (rst)
    (state == S_GCD || state == S_DIV) |-> gb != '0)
    else $error("gcd operand or divisor is zero");

  a_result_from_emit : assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_EMIT)
    else $error("result word posted outside the emit state");

  a_den_zero_flagged : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (denominator != '0 || overflow))
    else $error("zero denominator delivered without overflow");

endmodule

`default_nettype wire

[tb/sv/fraction_sum_reducer_core_test.sv]
`timescale 1ns / 1ps

module fraction_sum_reducer_core_test;

  // The run ends when no word moves on either channel for this many cycles.
  // It sits far above the work that one closing character costs the block,
  // so it leaves a wide margin even behind a long receiver stall.
  localparam int IDLE_LIMIT   = 20000;
  // Cycles left to pass after the last expected result, so that a stray
  // extra result word would still be caught.
  localparam int DRAIN_CYCLES = 600;
  localparam int RANDOM_WORDS = 900;

  // Largest magnitude that fits the internal word.
  localparam longint unsigned WORD_LIM = (64'd1 << (fsr_pkg::WORD_BITS_DEF - 1)) - 64'd1;
  localparam longint NUM_MAX = 64'sd2147483647;
  localparam longint NUM_MIN = -64'sd2147483648;
  localparam longint DEN_MAX = 64'sd2147483647;

  typedef logic [7:0] char_q_t[$];

  typedef struct {
    logic signed [fsr_pkg::NUM_BITS-1:0] numerator;
    logic [fsr_pkg::DEN_BITS-1:0]        denominator;
    logic                                overflow;
  } fraction_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic char_valid = 1'b0;
  logic [7:0] ch = 8'h00;
  logic last = 1'b0;
  logic res_ready = 1'b0;
  wire char_ready;
  wire res_valid;
  wire signed [fsr_pkg::NUM_BITS-1:0] numerator;
  wire [fsr_pkg::DEN_BITS-1:0] denominator;
  wire overflow;

  fraction_sum_reducer_core dut (
    .clk(clk),
    .rst(rst),
    .char_valid(char_valid),
    .char_ready(char_ready),
    .ch(ch),
    .last(last),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .numerator(numerator),
    .denominator(denominator),
    .overflow(overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sums predicted for expressions already sent, oldest first.
  fraction_t expected_sums[$];
  int mismatches = 0;
  // Character words sent so far, ignored codes included.
  int words_sent = 0;
  // Characters left in the current sender burst.
  int burst_left = 0;

  // ---------------------------------------------------------------------
  // Predictor state: the running rational sum and the term being parsed.
  // ---------------------------------------------------------------------
  longint          run_num;
  longint          run_den;
  longint unsigned part_num;
  longint unsigned part_den;
  bit              part_neg;
  logic [1:0]      part_phase;
  int              parts_done;
  bit              after_sign;
  bit              ovf_sticky;
  // Set by the checked multiply and add while one term is being combined.
  bit              step_ovf;

  function automatic void clear_part();
    part_num   = 0;
    part_den   = 0;
    part_neg   = 1'b0;
    part_phase = fsr_pkg::PH_START;
  endfunction

  function automatic void reset_predictor();
    run_num    = 0;
    run_den    = 1;
    clear_part();
    parts_done = 0;
    after_sign = 1'b1;
    ovf_sticky = 1'b0;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return longint'(v < 0 ? -v : v);
  endfunction

  function automatic longint with_sign(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint mul_checked(longint a, longint b);
    longint unsigned ma;
    longint unsigned mb;
    ma = magnitude(a);
    mb = magnitude(b);
    if (ma != 0 && mb > WORD_LIM / ma) begin
      step_ovf = 1'b1;
      return 0;
    end
    return with_sign(ma * mb, (a < 0) != (b < 0));
  endfunction

  function automatic longint add_checked(longint a, longint b);
    longint unsigned ma;
    longint unsigned mb;
    if ((a < 0) == (b < 0)) begin
      ma = magnitude(a);
      mb = magnitude(b);
      if (ma > WORD_LIM - mb) begin
        step_ovf = 1'b1;
        return 0;
      end
      return with_sign(ma + mb, a < 0);
    end
    return a + b;
  endfunction

  function automatic longint unsigned euclid_gcd(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Decimal digit accumulation saturates at the word limit.
  function automatic longint unsigned push_digit(longint unsigned v, int unsigned d);
    if (v > (WORD_LIM - d) / 10) begin
      ovf_sticky = 1'b1;
      return WORD_LIM;
    end
    return v * 10 + d;
  endfunction

  // Fold the finished term into the running sum. The first term is taken
  // as written; later ones are combined and then reduced by their gcd.
  function automatic void close_term();
    longint n;
    longint d;
    longint nn;
    longint nd;
    longint p;
    longint q;
    longint unsigned g;
    n = with_sign(part_num, part_neg);
    d = longint'(part_den);
    if (part_den == 0) begin
      ovf_sticky = 1'b1;
      d = 1;
    end
    if (parts_done == 0) begin
      run_num = n;
      run_den = d;
    end else begin
      step_ovf = 1'b0;
      if (run_den == d) begin
        nn = add_checked(run_num, n);
        nd = d;
      end else begin
        p  = mul_checked(run_num, d);
        q  = mul_checked(n, run_den);
        nn = add_checked(p, q);
        nd = mul_checked(run_den, d);
      end
      // A combination that leaves the word range drops the term.
      if (step_ovf) begin
        ovf_sticky = 1'b1;
      end else begin
        g = euclid_gcd(magnitude(nn), longint'(nd));
        run_num = nn / longint'(g);
        run_den = nd / longint'(g);
      end
    end
    if (parts_done < 2) parts_done++;
    clear_part();
  endfunction

  // Advance the predictor by one accepted character word and queue the
  // expected sum when the word closes the expression.
  function automatic void predict_char(logic [7:0] c, logic is_last);
    fraction_t r;
    logic ovf;
    if (c == fsr_pkg::CH_PLUS || c == fsr_pkg::CH_MINUS) begin
      // A sign after a sign (or at the start) only folds into the term sign.
      if (after_sign) begin
        if (c == fsr_pkg::CH_MINUS) part_neg = !part_neg;
      end else begin
        if (part_phase != fsr_pkg::PH_START) close_term();
        part_neg = (c == fsr_pkg::CH_MINUS);
      end
      after_sign = 1'b1;
    end else if (c >= fsr_pkg::CH_ZERO && c <= fsr_pkg::CH_NINE) begin
      if (part_phase == fsr_pkg::PH_DEN) begin
        part_den = push_digit(part_den, int'(c - fsr_pkg::CH_ZERO));
      end else begin
        part_num   = push_digit(part_num, int'(c - fsr_pkg::CH_ZERO));
        part_phase = fsr_pkg::PH_NUM;
      end
      after_sign = 1'b0;
    end else if (c == fsr_pkg::CH_SLASH) begin
      part_phase = fsr_pkg::PH_DEN;
      after_sign = 1'b0;
    end
    if (is_last) begin
      if (part_phase != fsr_pkg::PH_START) close_term();
      ovf = ovf_sticky;
      if (run_num > NUM_MAX || run_num < NUM_MIN) ovf = 1'b1;
      if (run_den > DEN_MAX) ovf = 1'b1;
      r.numerator   = run_num[fsr_pkg::NUM_BITS-1:0];
      r.denominator = run_den[fsr_pkg::DEN_BITS-1:0];
      r.overflow    = ovf;
      expected_sums.insert(expected_sums.size(), r);
      reset_predictor();
    end
  endfunction

  // ---------------------------------------------------------------------
  // Sender. Words go out in bursts of random length; between most bursts valid
  // drops, and some bursts follow with no gap at all.
  // ---------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        char_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    char_valid <= 1'b1;
    ch         <= c;
    last       <= is_last;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    burst_left--;
    words_sent++;
    predict_char(c, is_last);
  endtask

  task automatic send_expression(input char_q_t text);
    int i;
    for (i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
  endtask

  // Adds one character at the end of an expression.
  function automatic void append_char(ref char_q_t text, input logic [7:0] c);
    text.insert(text.size(), c);
  endfunction

  function automatic char_q_t to_chars(string s);
    char_q_t text;
    int i;
    for (i = 0; i < s.len(); i++) append_char(text, s[i]);
    return text;
  endfunction

  function automatic void append_number(ref char_q_t text, input longint unsigned v);
    string s;
    int i;
    s = $sformatf("%0d", v);
    for (i = 0; i < s.len(); i++) append_char(text, s[i]);
  endfunction

  function automatic logic [7:0] pick_sign();
    return $urandom_range(0, 1) ? fsr_pkg::CH_MINUS : fsr_pkg::CH_PLUS;
  endfunction

  // Mostly small magnitudes so that sums stay in range and reduce often;
  // now and then a value long enough to saturate the digit accumulator.
  function automatic longint unsigned pick_value(bit for_den);
    case ($urandom_range(0, 19))
      0:       return for_den ? 0 : $urandom_range(0, 12);
      1, 2:    return $urandom_range(0, 99999);
      3:       return {$urandom(), $urandom()} % 64'd200000000000;
      4, 5:    return $urandom_range(0, 999);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // Well-formed sums of one to four terms with random content, with the
  // occasional doubled sign, leading zero, missing part, stray slash or
  // random character code mixed in.
  function automatic char_q_t random_expression();
    char_q_t text;
    int terms;
    int i;
    terms = $urandom_range(1, 4);
    if ($urandom_range(0, 3) == 0) append_char(text, pick_sign());
    for (i = 0; i < terms; i++) begin
      if (i > 0) append_char(text, pick_sign());
      if ($urandom_range(0, 4) == 0) append_char(text, pick_sign());
      if ($urandom_range(0, 9) == 0) append_char(text, fsr_pkg::CH_ZERO);
      if ($urandom_range(0, 19) != 0) append_number(text, pick_value(1'b0));
      if ($urandom_range(0, 7) != 0) begin
        append_char(text, fsr_pkg::CH_SLASH);
        if ($urandom_range(0, 24) == 0) append_char(text, fsr_pkg::CH_SLASH);
        if ($urandom_range(0, 19) != 0) append_number(text, pick_value(1'b1));
      end
    end
    if ($urandom_range(0, 9) == 0) append_char(text, pick_sign());
    if ($urandom_range(0, 5) == 0)
      text.insert($urandom_range(0, text.size()), 8'($urandom_range(0, 255)));
    return text;
  endfunction

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------
  task automatic test_directed();
    char_q_t text;
    send_expression(to_chars("-1/2+1/3"));
    // A lone term is passed through without reduction.
    send_expression(to_chars("4/8"));
    // Separator minus followed by a negative term adds.
    send_expression(to_chars("1/3--1/3"));
    send_expression(to_chars("--3/4"));
    // Zero sum reduces to 0/1.
    send_expression(to_chars("1/2-1/2"));
    // Slash with no numerator, and a zero denominator.
    send_expression(to_chars("/0"));
    // A second slash is skipped and the digits go on into the denominator.
    send_expression(to_chars("7/2/3"));
    // Only signs: no term at all.
    send_expression(to_chars("+-"));
    // Code 0 and code 255 are ignored, the latter closing the expression.
    text = to_chars("5/6");
    text.push_front(8'h00);
    append_char(text, 8'hFF);
    send_expression(text);
  endtask

  task automatic test_word_limits();
    // Digit accumulation saturates.
    send_expression(to_chars("99999999999/7"));
    // Same-denominator add past the word limit drops the second term.
    send_expression(to_chars("2147483647/1+1/1"));
    // Cross-multiplied denominator past the word limit.
    send_expression(to_chars("65536/65537+1/65539"));
    send_expression(to_chars("-2147483647/2147483647"));
    // Missing denominator on a later term.
    send_expression(to_chars("9/2+7"));
  endtask

  task automatic test_random_sums();
    while (words_sent < RANDOM_WORDS * 4 / 5) send_expression(random_expression());
  endtask

  // Broken sequences: any codes at all, biased toward meaningful ones.
  task automatic test_malformed();
    char_q_t text;
    string alphabet;
    int n;
    int i;
    alphabet = "0123456789/+-";
    while (words_sent < RANDOM_WORDS) begin
      text.delete();
      n = $urandom_range(1, 10);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 1))
          append_char(text, alphabet[$urandom_range(0, alphabet.len() - 1)]);
        else
          append_char(text, 8'($urandom_range(0, 255)));
      end
      send_expression(text);
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver. It switches between stretches that are always ready, that
  // stall at random, and that stall most of the time.
  // ---------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left  = 0;

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      mode_left <= 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(8, 64);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       res_ready <= 1'b1;
        1:       res_ready <= $urandom_range(0, 1);
        default: res_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Every result word is checked against the oldest predicted sum.
  always @(posedge clk) begin : check_results
    fraction_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_sums.size() == 0) begin
        $error("result word with no sum expected: %0d/%0d overflow %0b",
               numerator, denominator, overflow);
        mismatches++;
      end else begin
        want = expected_sums.pop_front();
        if (numerator !== want.numerator) begin
          $error("numerator: expected %0d, got %0d", want.numerator, numerator);
          mismatches++;
        end
        if (denominator !== want.denominator) begin
          $error("denominator: expected %0d, got %0d", want.denominator, denominator);
          mismatches++;
        end
        if (overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, overflow);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a run in which no word moves for too long has hung.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (char_valid && char_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    reset_predictor();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_word_limits();
    test_random_sums();
    test_malformed();
    // The final word was accepted at this edge; release the channel.
    char_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_sums.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
hw/rtl/fsr_pkg.sv
hw/rtl/fraction_sum_reducer_core.sv
tb/sv/fraction_sum_reducer_core_test.sv
